### rtl/quadrature_encoder_tracker_defines.svh
// ----------------------------------------------------------------------------
// Quadrature encoder tracker assertion macros
// Shared property forms for the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef QUADRATURE_ENCODER_TRACKER_DEFINES_SVH
`define QUADRATURE_ENCODER_TRACKER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define QET_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("quadrature encoder tracker check failed");

// Next-cycle implication, disabled during reset.
`define QET_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("quadrature encoder tracker check failed");

`endif

### rtl/qet_pkg.sv
// ----------------------------------------------------------------------------
// Quadrature encoder tracker package
// Types, codes and widths shared by the tracker modules.
// ----------------------------------------------------------------------------
package qet_pkg;

   localparam int QET_TIME_BITS  = 32;
   localparam int QET_TIME_W     = 32;
   localparam int QET_CNT_W      = 16;
   localparam int QET_NUM_W      = 48;
   localparam int QET_DIVISOR_W  = 34;
   localparam int QET_STEP_W     = $clog2(QET_NUM_W + 1);
   localparam int QET_SPEED_W    = 48;
   localparam int QET_MAG_W      = 47;

   localparam logic [QET_CNT_W-1:0]   QET_CPR_RESET   = 16'd512;
   localparam logic [QET_TIME_W-1:0]  QET_CLOCK_RESET = 32'd36000000;
   localparam logic [QET_MAG_W-1:0]   QET_SPEED_MAX   = {QET_MAG_W{1'b1}};

   typedef enum logic [1:0] {
      OP_CAP_A,
      OP_CAP_B,
      OP_WRAP,
      OP_QUERY
   } op_type;

   typedef enum logic [1:0] {
      CSR_COUNTS_PER_REV,
      CSR_POSITION_OFFSET,
      CSR_CAPTURE_PRESCALER,
      CSR_CLOCK_HZ
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_MUL,
      ST_CHK,
      ST_DIVP,
      ST_DIVB,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic                  strobe;
      op_type                op;
      logic [QET_TIME_W-1:0] cap;
      logic [QET_CNT_W-1:0]  cnt;
   } event_type;

   typedef struct packed {
      logic [QET_TIME_W-1:0] time_a;
      logic [QET_TIME_W-1:0] time_b;
      logic [QET_TIME_W-1:0] period;
      logic [QET_CNT_W-1:0]  count_now;
      logic [31:0]           revolutions;
      logic                  dir_neg;
   } track_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

### rtl/qet_track.sv
// ----------------------------------------------------------------------------
// Quadrature encoder tracking state
// Holds timestamps, period, counter values, revolutions and direction.
// ----------------------------------------------------------------------------
module qet_track
   import qet_pkg::*;
#(
   parameter int TIME_BITS = QET_TIME_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 clear,
   input  logic [QET_CNT_W-1:0] counts_per_rev,
   input  event_type            evt,
   output track_type            trk
);

   logic [TIME_BITS-1:0] time_a_ff, time_a_in;
   logic [TIME_BITS-1:0] time_b_ff, time_b_in;
   logic [TIME_BITS-1:0] period_ff, period_in;
   logic [QET_CNT_W-1:0] count_now_ff, count_now_in;
   logic [QET_CNT_W-1:0] count_prev_ff, count_prev_in;
   logic [31:0]          revs_ff, revs_in;
   logic                 dir_neg_ff, dir_neg_in;

   logic [TIME_BITS-1:0]        cap;
   logic [TIME_BITS-1:0]        old_time;
   logic signed [QET_CNT_W:0]   step;
   logic signed [QET_CNT_W:0]   wrap;
   logic                        big;

   assign cap      = evt.cap[TIME_BITS-1:0];
   assign old_time = (evt.op == OP_CAP_A) ? time_a_ff : time_b_ff;
   assign step     = $signed({1'b0, evt.cnt}) - $signed({1'b0, count_now_ff});
   assign wrap     = $signed({1'b0, counts_per_rev}) - 17'sd1;
   assign big      = counts_per_rev >= 16'd3;

   always_comb begin
      time_a_in     = time_a_ff;
      time_b_in     = time_b_ff;
      period_in     = period_ff;
      count_now_in  = count_now_ff;
      count_prev_in = count_prev_ff;
      revs_in       = revs_ff;
      dir_neg_in    = dir_neg_ff;
      if (clear) begin
         time_a_in     = '0;
         time_b_in     = '0;
         count_now_in  = '0;
         count_prev_in = '0;
         revs_in       = '1;
      end else if (evt.strobe) begin
         case (evt.op)
            OP_CAP_A, OP_CAP_B: begin
               if (evt.op == OP_CAP_A) begin
                  time_a_in = cap;
               end else begin
                  time_b_in = cap;
               end
               period_in     = cap - old_time;
               count_prev_in = count_now_ff;
               count_now_in  = evt.cnt;
               if (step == -17'sd1 || (big && step == wrap)) begin
                  dir_neg_in = 1'b1;
               end else if (step == 17'sd1 || (big && step == -wrap)) begin
                  dir_neg_in = 1'b0;
               end
            end
            OP_WRAP: begin
               count_now_in = evt.cnt;
               if (evt.cnt == '0) begin
                  revs_in = revs_ff + 32'd1;
               end else if ($signed({1'b0, evt.cnt}) == wrap) begin
                  revs_in = revs_ff - 32'd1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         time_a_ff     <= '0;
         time_b_ff     <= '0;
         period_ff     <= '0;
         count_now_ff  <= '0;
         count_prev_ff <= '0;
         revs_ff       <= '1;
         dir_neg_ff    <= 1'b0;
      end else begin
         time_a_ff     <= time_a_in;
         time_b_ff     <= time_b_in;
         period_ff     <= period_in;
         count_now_ff  <= count_now_in;
         count_prev_ff <= count_prev_in;
         revs_ff       <= revs_in;
         dir_neg_ff    <= dir_neg_in;
      end
   end

   assign trk.time_a      = QET_TIME_W'(time_a_ff);
   assign trk.time_b      = QET_TIME_W'(time_b_ff);
   assign trk.period      = QET_TIME_W'(period_ff);
   assign trk.count_now   = count_now_ff;
   assign trk.revolutions = revs_ff;
   assign trk.dir_neg     = dir_neg_ff;

endmodule

### rtl/qet_div.sv
// ----------------------------------------------------------------------------
// Quadrature encoder tracker divider
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module qet_div
   import qet_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [QET_NUM_W-1:0]     dividend,
   input  logic [QET_DIVISOR_W-1:0] divisor,
   output logic [QET_NUM_W-1:0]     quotient,
   output div_status_type           status
);

   logic [QET_NUM_W-1:0]     quo_ff, quo_in;
   logic [QET_DIVISOR_W:0]   rem_ff, rem_in;
   logic [QET_DIVISOR_W-1:0] dsr_ff, dsr_in;
   logic [QET_STEP_W-1:0]    steps_ff, steps_in;
   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;

   logic [QET_DIVISOR_W:0]   rem_sh;
   logic [QET_DIVISOR_W+1:0] diff;
   logic                     fits;

   assign rem_sh = {rem_ff[QET_DIVISOR_W-1:0], quo_ff[QET_NUM_W-1]};
   assign diff   = {1'b0, rem_sh} - {2'b00, dsr_ff};
   assign fits   = !diff[QET_DIVISOR_W+1];

   always_comb begin
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      dsr_in   = dsr_ff;
      steps_in = steps_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         quo_in   = dividend;
         rem_in   = '0;
         dsr_in   = divisor;
         steps_in = QET_STEP_W'(QET_NUM_W);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         quo_in   = {quo_ff[QET_NUM_W-2:0], fits};
         rem_in   = fits ? diff[QET_DIVISOR_W:0] : rem_sh;
         steps_in = steps_ff - QET_STEP_W'(1);
         if (steps_ff == QET_STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         steps_ff <= '0;
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         steps_ff <= steps_in;
         busy_ff  <= busy_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign quotient    = quo_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

### rtl/quadrature_encoder_tracker.sv
// ----------------------------------------------------------------------------
// Quadrature encoder tracker
// Position and speed tracking from encoder capture, wrap and query items.
// ----------------------------------------------------------------------------
// The req channel carries one event item: a capture on channel A or B, a
// counter wrap, or a query. Every item yields exactly one rsp item with the
// position, the last edge period, the direction and, for a query, the
// bounded period and a signed Q31.16 speed in revolutions per second.
// Both channels are valid/ready; csr writes land without wait.
// A capture or wrap item passes the EXEC, MUL and DONE states up to the
// result register. A query also passes CHK, DIVP and DIVB, which use the
// shared one-bit-per-cycle divider twice: clock by period, then by the
// count base. When the period or the base is zero, the divider is skipped.
// One item is in work at a time; req_ready is high while the sequencer idles.
// The result sits in an output register, so a new item is accepted while
// the previous result waits; a stalled receiver holds a finished item in
// the sequencer until the register is free. Reset restores the register
// defaults and the tracking state, and empties the output register.
// ----------------------------------------------------------------------------
`include "quadrature_encoder_tracker_defines.svh"

module quadrature_encoder_tracker
   import qet_pkg::*;
#(
   parameter int TIME_BITS = QET_TIME_BITS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [1:0]                req_opcode,
   input  logic [31:0]               req_capture_time,
   input  logic [15:0]               req_count_value,
   input  logic [31:0]               req_now_time,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [31:0]        rsp_position,
   output logic [31:0]               rsp_edge_period,
   output logic [31:0]               rsp_bounded_period,
   output logic signed [1:0]         rsp_direction,
   output logic signed [QET_SPEED_W-1:0] rsp_speed_q16,
   input  logic                      csr_we,
   input  logic [1:0]                csr_index,
   input  logic [31:0]               csr_wdata
);

   state_type state_ff, state_in;

   logic [QET_CNT_W-1:0]  cpr_ff;
   logic [31:0]           offset_ff;
   logic [QET_CNT_W-1:0]  presc_ff;
   logic [QET_TIME_W-1:0] clock_hz_ff;

   op_type               op_ff;
   logic [TIME_BITS-1:0] cap_ff;
   logic [QET_CNT_W-1:0] cnt_ff;
   logic [TIME_BITS-1:0] now_ff;

   logic [31:0]              prod_ff;
   logic [QET_DIVISOR_W-1:0] base_ff;
   logic [QET_TIME_W-1:0]    bounded_ff;
   logic [QET_TIME_W-1:0]    per_ff;
   logic [QET_MAG_W-1:0]     mag_ff;

   logic                       rsp_valid_ff;
   logic signed [31:0]         rsp_position_ff;
   logic [31:0]                rsp_edge_period_ff;
   logic [31:0]                rsp_bounded_period_ff;
   logic signed [1:0]          rsp_direction_ff;
   logic signed [QET_SPEED_W-1:0] rsp_speed_ff;

   logic                     req_accept;
   logic                     cfg_clear;
   logic                     rsp_load;
   logic                     div_start;
   logic                     speed_zero;
   event_type                evt;
   track_type                trk;
   div_status_type           div_st;
   logic [QET_NUM_W-1:0]     div_dividend;
   logic [QET_DIVISOR_W-1:0] div_divisor;
   logic [QET_NUM_W-1:0]     div_quotient;
   logic [QET_TIME_W-1:0]    older;
   logic [TIME_BITS-1:0]     bounded_now;
   logic [QET_TIME_W-1:0]    bounded_ext;
   logic [QET_MAG_W-1:0]     quo_sat;
   logic [QET_SPEED_W-1:0]   speed_signed;
   logic                     is_query;

   assign req_accept = req_valid && req_ready;
   assign cfg_clear  = csr_we && (csr_index == CSR_COUNTS_PER_REV);
   assign is_query   = (op_ff == OP_QUERY);
   assign speed_zero = (per_ff == '0) || (base_ff == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         cpr_ff      <= QET_CPR_RESET;
         offset_ff   <= '0;
         presc_ff    <= '0;
         clock_hz_ff <= QET_CLOCK_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_COUNTS_PER_REV:    cpr_ff      <= csr_wdata[QET_CNT_W-1:0];
            CSR_POSITION_OFFSET:   offset_ff   <= csr_wdata;
            CSR_CAPTURE_PRESCALER: presc_ff    <= csr_wdata[QET_CNT_W-1:0];
            CSR_CLOCK_HZ:          clock_hz_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         op_ff  <= op_type'(req_opcode);
         cap_ff <= req_capture_time[TIME_BITS-1:0];
         cnt_ff <= req_count_value;
         now_ff <= req_now_time[TIME_BITS-1:0];
      end
   end

   assign evt.strobe = (state_ff == ST_EXEC);
   assign evt.op     = op_ff;
   assign evt.cap    = QET_TIME_W'(cap_ff);
   assign evt.cnt    = cnt_ff;

   qet_track #(
      .TIME_BITS (TIME_BITS)
   ) u_track (
      .clock          (clock),
      .reset          (reset),
      .clear          (cfg_clear),
      .counts_per_rev (cpr_ff),
      .evt            (evt),
      .trk            (trk)
   );

   assign older       = (trk.time_b > trk.time_a) ? trk.time_a : trk.time_b;
   assign bounded_now = now_ff - older[TIME_BITS-1:0];
   assign bounded_ext = QET_TIME_W'(bounded_now);

   always_ff @(posedge clock) begin
      if (state_ff == ST_MUL) begin
         prod_ff    <= 32'(trk.revolutions * cpr_ff);
         base_ff    <= {(QET_DIVISOR_W-1)'(cpr_ff) *
                        (QET_DIVISOR_W-1)'({1'b0, presc_ff} + 17'd1), 1'b0};
         bounded_ff <= bounded_ext;
         per_ff     <= (trk.period > bounded_ext) ? trk.period : bounded_ext;
      end
   end

   assign div_dividend = (state_ff == ST_CHK) ? {clock_hz_ff, 16'h0000} : div_quotient;
   assign div_divisor  = (state_ff == ST_CHK) ? QET_DIVISOR_W'(per_ff) : base_ff;

   qet_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .quotient (div_quotient),
      .status   (div_st)
   );

   assign quo_sat = (div_quotient > QET_NUM_W'(QET_SPEED_MAX)) ? QET_SPEED_MAX
                                                               : div_quotient[QET_MAG_W-1:0];

   always_ff @(posedge clock) begin
      if (state_ff == ST_CHK && speed_zero) begin
         mag_ff <= QET_SPEED_MAX;
      end else if (state_ff == ST_DIVB && div_st.done) begin
         mag_ff <= quo_sat;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      div_start = 1'b0;
      rsp_load  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_MUL;
         end
         ST_MUL: begin
            state_in = is_query ? ST_CHK : ST_DONE;
         end
         ST_CHK: begin
            if (speed_zero) begin
               state_in = ST_DONE;
            end else begin
               div_start = 1'b1;
               state_in  = ST_DIVP;
            end
         end
         ST_DIVP: begin
            if (div_st.done) begin
               div_start = 1'b1;
               state_in  = ST_DIVB;
            end
         end
         ST_DIVB: begin
            if (div_st.done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign speed_signed = trk.dir_neg ? (QET_SPEED_W'(0) - {1'b0, mag_ff}) : {1'b0, mag_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_position_ff       <= 32'(trk.count_now) + prod_ff + offset_ff;
         rsp_edge_period_ff    <= trk.period;
         rsp_bounded_period_ff <= is_query ? bounded_ff : '0;
         rsp_direction_ff      <= trk.dir_neg ? 2'sb11 : 2'sb01;
         rsp_speed_ff          <= is_query ? speed_signed : '0;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_position       = rsp_position_ff;
   assign rsp_edge_period    = rsp_edge_period_ff;
   assign rsp_bounded_period = rsp_bounded_period_ff;
   assign rsp_direction      = rsp_direction_ff;
   assign rsp_speed_q16      = rsp_speed_ff;

   `QET_ASSERT_NEXT(a_accept_to_exec, clock, reset, req_accept, state_ff == ST_EXEC)
   `QET_ASSERT_NOW(a_div_only_in_div_states, clock, reset, div_st.busy,
                   state_ff == ST_DIVP || state_ff == ST_DIVB)
   `QET_ASSERT_NEXT(a_load_sets_valid, clock, reset, rsp_load,
                    rsp_valid_ff && state_ff == ST_IDLE)

endmodule
